FILE: src/rrts_pkg.sv
// Package for the round-robin task scheduler: payload structs, task constants,
// controller state encoding and the task-table control struct.
// No dependencies.
package rrts_pkg;

	// Task slots; slot 0 is the idle task
	localparam int TASKS  = 5;
	localparam int TASK_W = 3;
	localparam int TICK_W = 32;

	localparam logic [TASK_W-1:0] IDLE_TASK  = TASK_W'(0);
	localparam logic [TASK_W-1:0] FIRST_TASK = TASK_W'(1);
	localparam logic [TASK_W-1:0] LAST_TASK  = TASK_W'(TASKS - 1);

	// Command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_DELAY = 1'b1;

	typedef struct packed {
		logic              command;
		logic [TICK_W-1:0] delay_ticks;
	} cmd_t;

	typedef struct packed {
		logic [TASK_W-1:0] running_task;
		logic [TICK_W-1:0] tick_now;
	} res_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAKE,
		ST_PICK
	} state_t;

	// Control from the sequencer to the task table
	typedef struct packed {
		logic              blk_set; // write wake tick and block the task
		logic              chk;     // compare wake tick and wake on match
		logic [TASK_W-1:0] idx;
		logic [TICK_W-1:0] val;     // wake tick to write, or tick to compare
	} tbl_ctl_t;

endpackage

FILE: src/rrts_task_table.sv
// Task table: per-task wake ticks, blocked flags and the shared wake comparator.
// Depends on rrts_pkg.
module rrts_task_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrts_pkg::tbl_ctl_t            ctl,
	output logic [rrts_pkg::TASKS-1:0]    blocked
);
	import rrts_pkg::*;

	logic [TICK_W-1:0] wake_q [TASKS];
	logic [TASKS-1:0]  blocked_q;
	logic              match;

	// Shared compare: the addressed task is due at the given tick
	assign match = blocked_q[ctl.idx] && (wake_q[ctl.idx] == ctl.val);

	// Wake tick storage, written only when a task blocks
	always_ff @(posedge clk) begin
		if (ctl.blk_set) begin
			wake_q[ctl.idx] <= ctl.val;
		end
	end

	// Blocked flags; idle slot is never set by the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q <= '0;
		end else if (ctl.blk_set) begin
			blocked_q[ctl.idx] <= 1'b1;
		end else if (ctl.chk && match) begin
			blocked_q[ctl.idx] <= 1'b0;
		end
	end

	assign blocked = blocked_q;

endmodule

FILE: src/rrts_ctrl.sv
// Scheduler sequencer: tick count, running task, wake scan and task pick,
// result register. Depends on rrts_pkg; drives rrts_task_table.
module rrts_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  rrts_pkg::cmd_t             cmd,
	output logic                       res_valid,
	input  logic                       res_ready,
	output rrts_pkg::res_t             res,
	output rrts_pkg::tbl_ctl_t         tbl_ctl,
	input  logic [rrts_pkg::TASKS-1:0] blocked
);
	import rrts_pkg::*;

	state_t            state_q, state_d;
	logic [TICK_W-1:0] tick_q;
	logic [TASK_W-1:0] cur_q;
	logic [TASK_W-1:0] idx_q;
	logic              resched_q;
	logic              res_valid_q;
	res_t              res_q;

	logic              cmd_xfer;
	logic              load_res;
	logic              do_tick;
	logic              do_delay;
	logic [TASK_W-1:0] pick;
	logic [TASK_W:0]   sum;
	logic [TASK_W-1:0] cand;

	assign cmd_xfer = cmd_valid && cmd_ready;
	assign do_tick  = cmd_xfer && (cmd.command == CMD_TICK);
	assign do_delay = cmd_xfer && (cmd.command == CMD_DELAY) && (cur_q != IDLE_TASK);

	// Round-robin pick: rotation after the running task, idle skipped,
	// running task tried last, idle if nothing is ready
	always_comb begin
		pick = IDLE_TASK;
		sum  = '0;
		cand = '0;
		if (cur_q != IDLE_TASK && !blocked[cur_q]) begin
			pick = cur_q;
		end
		for (int k = TASKS - 1; k >= 1; k--) begin
			sum = {1'b0, cur_q} + (TASK_W+1)'(k);
			if (sum >= (TASK_W+1)'(TASKS)) begin
				sum = sum - (TASK_W+1)'(TASKS);
			end
			cand = sum[TASK_W-1:0];
			if (cand != IDLE_TASK && !blocked[cand]) begin
				pick = cand;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (do_tick) begin
					state_d = ST_WAKE;
				end else if (cmd_xfer) begin
					state_d = ST_PICK;
				end
			end
			ST_WAKE: begin
				if (idx_q == LAST_TASK) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (load_res) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		cmd_ready       = 1'b0;
		load_res        = 1'b0;
		tbl_ctl.blk_set = 1'b0;
		tbl_ctl.chk     = 1'b0;
		tbl_ctl.idx     = idx_q;
		tbl_ctl.val     = tick_q;
		case (state_q)
			ST_IDLE: begin
				cmd_ready       = 1'b1;
				tbl_ctl.blk_set = do_delay;
				tbl_ctl.idx     = cur_q;
				tbl_ctl.val     = tick_q + cmd.delay_ticks;
			end
			ST_WAKE: begin
				tbl_ctl.chk = 1'b1;
			end
			ST_PICK: begin
				load_res = !res_valid_q || res_ready;
			end
			default: ;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			cur_q       <= FIRST_TASK;
			idx_q       <= FIRST_TASK;
			resched_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_xfer) begin
				resched_q <= do_tick || do_delay;
				idx_q     <= FIRST_TASK;
			end else if (state_q == ST_WAKE) begin
				idx_q <= idx_q + FIRST_TASK;
			end
			if (do_tick) begin
				tick_q <= tick_q + TICK_W'(1);
			end
			if (load_res && resched_q) begin
				cur_q <= pick;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.running_task <= resched_q ? pick : cur_q;
			res_q.tick_now     <= tick_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: src/round_robin_task_scheduler.sv
// Round-robin task scheduler, top level.
// Tick: after the input transfer, one wake compare per non-idle task
// (ST_WAKE), then the pick (ST_PICK), held while a result is untaken.
// Delay: blocks the running task, then ST_PICK. Inputs only in ST_IDLE.
// Reset: tick count 0, task 1 running, all tasks ready; no clearing pass.
// Depends on rrts_pkg, rrts_task_table, rrts_ctrl.
module round_robin_task_scheduler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  rrts_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output rrts_pkg::res_t res
);
	import rrts_pkg::*;

	tbl_ctl_t         tbl_ctl;
	logic [TASKS-1:0] blocked;

	// Sequencer
	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.tbl_ctl   (tbl_ctl),
		.blocked   (blocked)
	);

	// Task table with shared wake comparator
	rrts_task_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.blocked (blocked)
	);

endmodule

FILE: src/rrts_checker.sv
// Port-level checks for the round-robin task scheduler, bound to the top level.
// Depends on rrts_pkg.
module rrts_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input rrts_pkg::cmd_t cmd,
	input logic           res_valid,
	input logic           res_ready,
	input rrts_pkg::res_t res
);
	import rrts_pkg::*;

	// A waiting input holds its payload until its transfer
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("input changed while stalled");

	// A waiting result holds until its transfer
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// One item at a time: busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("input taken while busy");

	// A new result comes only out of a busy period
	a_res_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!cmd_ready))
		else $error("result without work");

	// Running task is a valid slot
	a_task_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.running_task <= LAST_TASK)
		else $error("running task out of range");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);
